// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL; they compile away under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising clock edge outside reset.
`define ASSERT_PROP(label, clk_sig, rst_sig, prop) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (prop)) \
    else $error("assertion failed");

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk_sig, rst_sig, expr) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk_sig, rst_sig, prop)
`define ASSERT_NEVER(label, clk_sig, rst_sig, expr)

`endif

`endif

// ===== src/dpa_pkg.sv =====
package dpa_pkg;

  // Field widths
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned ROW_W   = 10;
  localparam int unsigned CNT_W   = 20;
  localparam int unsigned BIN_W   = 16;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned CFG_W   = 10;

  // Packed stream widths
  localparam int unsigned S_DATA_W = 40;
  localparam int unsigned M_DATA_W = 128;

  // Column histogram
  localparam int unsigned HIST_DEPTH = 1024;
  localparam int unsigned HIST_AW    = $clog2(HIST_DEPTH);

  // Words at or above this value are row delimiters
  localparam int unsigned ROW_MARK     = 1024;
  localparam int unsigned ROW_MARK_LOG = $clog2(ROW_MARK);

  // Remainder by ROW_MARK through a reciprocal multiply, exact for 16-bit words
  localparam int unsigned DIV_SHIFT      = WORD_W + ROW_MARK_LOG;
  localparam logic [63:0] DIV_RECIP_FULL =
    ((64'd1 << DIV_SHIFT) + 64'(ROW_MARK) - 64'd1) / 64'(ROW_MARK);
  localparam int unsigned RECIP_W   = WORD_W + 2;
  localparam logic [RECIP_W-1:0] DIV_RECIP = DIV_RECIP_FULL[RECIP_W-1:0];
  localparam int unsigned PROD_W    = WORD_W + RECIP_W;
  localparam int unsigned QUOT_W    = WORD_W - ROW_MARK_LOG + 1;
  localparam int unsigned REM_W     = (ROW_MARK_LOG < 1) ? 1 : ROW_MARK_LOG;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_END_ROW    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTROID_X = 1'd1;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 2'd0,
    OP_START = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

endpackage

// ===== src/dpa_ram.sv =====
module dpa_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/density_projection_accumulator.sv =====
// Row density and column projection accumulator. Each request on the s_ stream carries
// an op in s_tuser: push a buffer word, start a section, or read and clear one column
// histogram bin; s_tlast marks the final buffer word. A pushed word below the row mark
// is a lit-pixel column: it bumps the left or right count against centroid_x and its
// 16-bit histogram bin. A word at or above the mark closes the current row, reports
// its density, and names the next row (word modulo the mark); a row at or past end_row
// stops the section. Every request yields exactly one result request on the m_ stream,
// with m_tuser flagging a closed row. Throughput is one request per clock while the m_
// stream and the clear pass do not stall; each request passes in order through the
// reciprocal multiply, remainder fixup, histogram read-modify-write and output register
// stages. The histogram lives in a single 1024 x 16 two-port RAM with a registered
// read; a write-forward register covers the back-to-back case where consecutive
// requests touch the same bin. After reset the block zeroes every histogram bin, with
// s_tready low; configuration writes are taken at any time and take effect at once,
// so issue them only while no request is in flight.
module density_projection_accumulator
  import dpa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // input stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_DATA_W-1:0]  s_tdata,   // word[15:0], start_row[25:16], bin_index[35:26]
  input  logic [OP_W-1:0]      s_tuser,   // op[1:0]
  input  logic                 s_tlast,   // last_word
  // result stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_DATA_W-1:0]  m_tdata,   // row_index[9:0], row_density[29:10],
                                          // left_total[49:30], right_total[69:50],
                                          // words_taken[89:70], last_value[105:90],
                                          // section_done[106], bin_value[122:107]
  output logic                 m_tuser,   // row_valid
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  `include "assert_macros.svh"

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  logic [ROW_W-1:0] end_row;
  logic [ROW_W-1:0] centroid_x;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      end_row    <= '0;
      centroid_x <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_END_ROW:    end_row    <= cfg_data;
        CFG_CENTROID_X: centroid_x <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Histogram clear pass after reset
  // ---------------------------------------------------------------------------
  logic               clr_busy;
  logic [HIST_AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + HIST_AW'(1);
      if (clr_addr == HIST_AW'(HIST_DEPTH - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control
  // ---------------------------------------------------------------------------
  logic p1_valid, p2_valid, p3_valid;
  logic out_ready, p3_ready, p2_ready, p1_ready;
  logic commit;

  assign out_ready = !m_tvalid || m_tready;
  assign commit    = p3_valid && out_ready;
  assign p3_ready  = !p3_valid || out_ready;
  assign p2_ready  = !p2_valid || p3_ready;
  assign p1_ready  = !p1_valid || p2_ready;
  assign s_tready  = p1_ready && !clr_busy;

  // ---------------------------------------------------------------------------
  // Stage 1: capture the request, estimate word / ROW_MARK
  // ---------------------------------------------------------------------------
  logic [WORD_W-1:0] in_word;
  logic [PROD_W-1:0] in_prod;

  assign in_word = s_tdata[WORD_W-1:0];
  assign in_prod = PROD_W'(in_word) * PROD_W'(DIV_RECIP);

  op_t                p1_op;
  logic [WORD_W-1:0]  p1_word;
  logic [ROW_W-1:0]   p1_start_row;
  logic [ROW_W-1:0]   p1_bin;
  logic               p1_last;
  logic [QUOT_W-1:0]  p1_quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (p1_ready) begin
      p1_valid <= s_tvalid && s_tready;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      p1_op        <= op_t'(s_tuser);
      p1_word      <= in_word;
      p1_start_row <= s_tdata[WORD_W +: ROW_W];
      p1_bin       <= s_tdata[WORD_W + ROW_W +: ROW_W];
      p1_last      <= s_tlast;
      p1_quot      <= QUOT_W'(in_prod >> DIV_SHIFT);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: remainder with one correction step, pick the histogram address
  // ---------------------------------------------------------------------------
  logic [WORD_W:0] p1_qd;
  logic [WORD_W:0] p1_rem_raw;
  logic [WORD_W:0] p1_rem;

  assign p1_qd      = (WORD_W + 1)'(p1_quot) * (WORD_W + 1)'(ROW_MARK);
  assign p1_rem_raw = {1'b0, p1_word} - p1_qd;
  assign p1_rem     = (p1_rem_raw >= (WORD_W + 1)'(ROW_MARK)) ?
                      p1_rem_raw - (WORD_W + 1)'(ROW_MARK) : p1_rem_raw;

  op_t                p2_op;
  logic [WORD_W-1:0]  p2_word;
  logic [ROW_W-1:0]   p2_start_row;
  logic               p2_last;
  logic [REM_W-1:0]   p2_rem;
  logic               p2_col;
  logic               p2_in_hist;
  logic [HIST_AW-1:0] p2_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else if (p2_ready) begin
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_valid && p2_ready) begin
      p2_op        <= p1_op;
      p2_word      <= p1_word;
      p2_start_row <= p1_start_row;
      p2_last      <= p1_last;
      p2_rem       <= REM_W'(p1_rem);
      p2_col       <= ({1'b0, p1_word} < (WORD_W + 1)'(ROW_MARK));
      p2_in_hist   <= ({1'b0, p1_word} < (WORD_W + 1)'(HIST_DEPTH));
      p2_addr      <= (p1_op == OP_READ) ? p1_bin : p1_word[HIST_AW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Histogram RAM; read issued as a request moves into stage 3
  // ---------------------------------------------------------------------------
  logic               ram_we;
  logic [HIST_AW-1:0] ram_waddr;
  logic [BIN_W-1:0]   ram_wdata;
  logic               ram_re;
  logic [BIN_W-1:0]   ram_rdata;

  assign ram_re = p2_valid && p3_ready;

  dpa_ram #(
    .WIDTH (BIN_W),
    .DEPTH (HIST_DEPTH)
  ) u_hist_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (p2_addr),
    .rdata (ram_rdata)
  );

  // Hold the most recent write: it covers the write the RAM missed at read time
  logic               fwd_valid;
  logic [HIST_AW-1:0] fwd_addr;
  logic [BIN_W-1:0]   fwd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (ram_we) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      fwd_addr <= ram_waddr;
      fwd_data <= ram_wdata;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: state update
  // ---------------------------------------------------------------------------
  op_t                p3_op;
  logic [WORD_W-1:0]  p3_word;
  logic [ROW_W-1:0]   p3_start_row;
  logic               p3_last;
  logic [REM_W-1:0]   p3_rem;
  logic               p3_col;
  logic               p3_in_hist;
  logic [HIST_AW-1:0] p3_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_valid <= 1'b0;
    end else if (p3_ready) begin
      p3_valid <= p2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (p2_valid && p3_ready) begin
      p3_op        <= p2_op;
      p3_word      <= p2_word;
      p3_start_row <= p2_start_row;
      p3_last      <= p2_last;
      p3_rem       <= p2_rem;
      p3_col       <= p2_col;
      p3_in_hist   <= p2_in_hist;
      p3_addr      <= p2_addr;
    end
  end

  logic [CNT_W-1:0]  left_count,  left_count_next;
  logic [CNT_W-1:0]  right_count, right_count_next;
  logic [CNT_W-1:0]  prev_total,  prev_total_next;
  logic [CNT_W-1:0]  word_count,  word_count_next;
  logic [ROW_W-1:0]  cur_row,     cur_row_next;
  logic              stopped,     stopped_next;
  logic [WORD_W-1:0] last_value,  last_value_next;

  logic [BIN_W-1:0]  hist_old;
  logic [CNT_W-1:0]  row_total;
  logic [WORD_W-1:0] rem_value;
  logic              hist_we_item;
  logic [BIN_W-1:0]  hist_wdata_item;
  logic              res_row_valid;
  logic [ROW_W-1:0]  res_row_index;
  logic [CNT_W-1:0]  res_density;
  logic [BIN_W-1:0]  res_bin;
  logic              res_done;

  assign hist_old  = (fwd_valid && fwd_addr == p3_addr) ? fwd_data : ram_rdata;
  assign row_total = left_count + right_count;
  assign rem_value = WORD_W'(p3_rem);

  always_comb begin
    left_count_next  = left_count;
    right_count_next = right_count;
    prev_total_next  = prev_total;
    word_count_next  = word_count;
    cur_row_next     = cur_row;
    stopped_next     = stopped;
    last_value_next  = last_value;
    hist_we_item     = 1'b0;
    hist_wdata_item  = '0;
    res_row_valid    = 1'b0;
    res_row_index    = '0;
    res_density      = '0;
    res_bin          = '0;
    case (p3_op)
      OP_START: begin
        left_count_next  = '0;
        right_count_next = '0;
        prev_total_next  = '0;
        word_count_next  = '0;
        last_value_next  = '0;
        cur_row_next     = p3_start_row;
        stopped_next     = (end_row == '0);
      end
      OP_READ: begin
        res_bin         = hist_old;
        hist_we_item    = 1'b1;
        hist_wdata_item = '0;
      end
      OP_PUSH: begin
        if (!stopped) begin
          word_count_next = word_count + CNT_W'(1);
          if (p3_col) begin
            if (p3_word < WORD_W'(centroid_x)) begin
              left_count_next = left_count + CNT_W'(1);
            end else begin
              right_count_next = right_count + CNT_W'(1);
            end
            hist_we_item    = p3_in_hist;
            hist_wdata_item = hist_old + BIN_W'(1);
            last_value_next = p3_word;
          end else begin
            // Row delimiter: close the row, drop the tag
            res_row_valid   = 1'b1;
            res_row_index   = cur_row;
            res_density     = row_total - prev_total;
            prev_total_next = row_total;
            last_value_next = rem_value;
            if (rem_value >= WORD_W'(end_row)) begin
              stopped_next = 1'b1;
            end else begin
              cur_row_next = ROW_W'(p3_rem);
            end
          end
          if (p3_last) begin
            stopped_next = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  assign res_done = (last_value_next >= WORD_W'(end_row));

  // The clear pass and stage 3 never overlap: no request is taken while clearing
  always_comb begin
    if (clr_busy) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = commit && hist_we_item;
      ram_waddr = p3_addr;
      ram_wdata = hist_wdata_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_count  <= '0;
      right_count <= '0;
      prev_total  <= '0;
      word_count  <= '0;
      cur_row     <= '0;
      stopped     <= 1'b0;
      last_value  <= '0;
    end else if (commit) begin
      left_count  <= left_count_next;
      right_count <= right_count_next;
      prev_total  <= prev_total_next;
      word_count  <= word_count_next;
      cur_row     <= cur_row_next;
      stopped     <= stopped_next;
      last_value  <= last_value_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_ready) begin
      m_tvalid <= p3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      m_tuser <= res_row_valid;
      m_tdata <= M_DATA_W'({res_bin, res_done, last_value_next, word_count_next,
                            right_count_next, left_count_next, res_density,
                            res_row_index});
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `ASSERT_NEVER(a_no_accept_while_clearing, clk, rst, clr_busy && s_tready)
  `ASSERT_NEVER(a_pipe_empty_while_clearing, clk, rst,
                clr_busy && (p1_valid || p2_valid || p3_valid))
  `ASSERT_PROP(a_read_clears_bin, clk, rst,
               (commit && p3_op == OP_READ) |->
               (ram_we && ram_waddr == p3_addr && ram_wdata == '0))
  `ASSERT_PROP(a_row_close_flagged, clk, rst,
               (commit && p3_op == OP_PUSH && !stopped && !p3_col) |=>
               (m_tvalid && m_tuser))
  `ASSERT_PROP(a_push_counts_word, clk, rst,
               (commit && p3_op == OP_PUSH && !stopped) |=>
               (word_count == $past(word_count) + CNT_W'(1)))

endmodule
